// ----- hw/rtl/qsl_pkg.sv -----
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int QSL_DEPTH   = 64;
    localparam int QSL_DATA_W  = 32;
    // A range entry holds a low and a high index of six bits each.
    localparam int QSL_FIELD_W = 6;
    localparam int QSL_ENTRY_W = 2 * QSL_FIELD_W;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SEED,
        S_NEXT,
        S_POP,
        S_POPW,
        S_PIVR,
        S_PIVW,
        S_RD,
        S_CMP,
        S_SWB,
        S_PUSHL,
        S_PUSHR,
        S_ORD,
        S_OWR
    } t_qsl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store an accepted beat
        logic seed;        // push the whole set as the first range
        logic pop;         // read the top range, drop the stack pointer
        logic take_range;  // latch low and high from the stack read data
        logic sel_hi;      // element port A reads the high index (pivot)
        logic take_pivot;  // latch the pivot, start i and j at low
        logic step;        // compare element j with the pivot, first write of a swap
        logic swap_hi;     // second write of a swap
        logic push_left;
        logic push_right;
        logic sel_k;       // element port A reads the output index
        logic emit;        // load the output register
        logic finish;      // clear the set state for the next set
    } t_qsl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sp_nz;       // ranges remain on the stack
        logic range_ok;    // popped range has two or more elements
        logic less;        // element j is below the pivot
        logic j_at_hi;     // scan reached the pivot position
        logic k_last;      // output index is the final element
        logic out_free;    // output register is empty by the end of this cycle
    } t_qsl_sts;

endpackage

// ----- hw/rtl/quicksort_lomuto_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                    tdata / tuser
// --------  ---------  -----------------------  ------------------------------------
// slave     in         i_s_tvalid/o_s_tready    tdata: value; tlast: last_in
// master    out        o_m_tvalid/i_m_tready    tdata: sorted_value; tlast: last_out;
//                                               tuser: overflow
//
// Loading takes one beat per cycle. After the last beat the sort runs with no beat
// accepted; a compare reads element j, then checks it, and a swap needs two writes,
// set by the single write port of the element store. Output reads the store, then
// loads the output register for each beat. Reset is synchronous and active low and
// needs no clearing pass. A stalled master side holds the current beat in the
// output register; the next set may start loading while the final beat still waits.

module quicksort_lomuto_top #(
    parameter int DEPTH = qsl_pkg::QSL_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [31:0] value
    input  logic signed [qsl_pkg::QSL_DATA_W-1:0] i_s_tdata,
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [31:0] sorted_value
    output logic signed [qsl_pkg::QSL_DATA_W-1:0] o_m_tdata,
    output logic                                 o_m_tlast,
    // [0] overflow
    output logic [0:0]                           o_m_tuser
);
    import qsl_pkg::*;

    t_qsl_cmd cmd;
    t_qsl_sts sts;
    logic     overflow;

    // The controller sequences loading, partitioning, stack handling and output.
    qsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the element store, the range stack and the output register.
    qsl_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_s_tdata),
        .i_m_tready     (i_m_tready),
        .o_m_tvalid     (o_m_tvalid),
        .o_sorted_value (o_m_tdata),
        .o_last_out     (o_m_tlast),
        .o_overflow     (overflow),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

    assign o_m_tuser = overflow;

endmodule

// ----- hw/rtl/qsl_ctrl.sv -----
`timescale 1ns / 1ps

module qsl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tlast,
    output logic              o_s_tready,
    input  qsl_pkg::t_qsl_sts i_sts,
    output qsl_pkg::t_qsl_cmd o_cmd
);
    import qsl_pkg::*;

    t_qsl_state r_state;
    t_qsl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_NEXT;
            end
            S_NEXT: begin
                n_state = i_sts.sp_nz ? S_POP : S_ORD;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_POPW;
            end
            S_POPW: begin
                o_cmd.take_range = 1'b1;
                n_state          = i_sts.range_ok ? S_PIVR : S_NEXT;
            end
            S_PIVR: begin
                o_cmd.sel_hi = 1'b1;
                n_state      = S_PIVW;
            end
            S_PIVW: begin
                o_cmd.take_pivot = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.step = 1'b1;
                n_state    = (i_sts.j_at_hi || i_sts.less) ? S_SWB : S_RD;
            end
            S_SWB: begin
                o_cmd.swap_hi = 1'b1;
                n_state       = i_sts.j_at_hi ? S_PUSHL : S_RD;
            end
            S_PUSHL: begin
                o_cmd.push_left = 1'b1;
                n_state         = S_PUSHR;
            end
            S_PUSHR: begin
                o_cmd.push_right = 1'b1;
                n_state          = S_NEXT;
            end
            S_ORD: begin
                o_cmd.sel_k = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_OWR;
                end
            end
            S_OWR: begin
                o_cmd.emit = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ----- hw/rtl/qsl_dp.sv -----
`timescale 1ns / 1ps

module qsl_dp #(
    parameter int DEPTH = qsl_pkg::QSL_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [qsl_pkg::QSL_DATA_W-1:0] i_value,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic signed [qsl_pkg::QSL_DATA_W-1:0] o_sorted_value,
    output logic                                 o_last_out,
    output logic                                 o_overflow,
    input  qsl_pkg::t_qsl_cmd                    i_cmd,
    output qsl_pkg::t_qsl_sts                    o_sts
);
    import qsl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Element store and range stack, both with registered reads.
    logic [QSL_DATA_W-1:0]  r_mem [DEPTH];
    logic [QSL_ENTRY_W-1:0] r_stk [DEPTH];

    logic [QSL_DATA_W-1:0]  r_rd_a;
    logic [QSL_DATA_W-1:0]  r_rd_b;
    logic [QSL_ENTRY_W-1:0] r_stk_rd;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_sp;
    logic                   r_ovf;
    logic [AW-1:0]          r_lo;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_i;
    logic [AW-1:0]          r_j;
    logic [AW-1:0]          r_k;
    logic [QSL_DATA_W-1:0]  r_pivot;
    logic                   r_ovalid;
    logic [QSL_DATA_W-1:0]  r_odata;
    logic                   r_olast;
    logic                   r_oovf;

    logic [AW-1:0]          addr_a;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [QSL_DATA_W-1:0]  mem_wdata;
    logic                   stk_we;
    logic [QSL_ENTRY_W-1:0] stk_wdata;
    logic [AW-1:0]          stk_raddr;
    logic [QSL_FIELD_W-1:0] pop_lo;
    logic [QSL_FIELD_W-1:0] pop_hi;
    logic                   has_room;
    logic                   stk_room;
    logic                   push_l_ok;
    logic                   push_r_ok;
    logic                   less;
    logic                   j_at_hi;
    logic                   k_last;

    assign has_room  = (r_count < CW'(DEPTH));
    assign stk_room  = (r_sp < CW'(DEPTH));
    assign less      = ($signed(r_rd_a) < $signed(r_pivot));
    assign j_at_hi   = (r_j == r_hi);
    assign k_last    = ((CW'(r_k) + CW'(1)) == r_count);
    assign pop_lo    = r_stk_rd[QSL_ENTRY_W-1:QSL_FIELD_W];
    assign pop_hi    = r_stk_rd[QSL_FIELD_W-1:0];
    // Compare one bit wider than the index so the sums cannot wrap.
    assign push_l_ok = ({1'b0, r_i} > ({1'b0, r_lo} + (AW + 1)'(1)));
    assign push_r_ok = (({1'b0, r_i} + (AW + 1)'(1)) < {1'b0, r_hi});
    assign stk_raddr = AW'(r_sp - CW'(1));

    always_comb begin
        if (i_cmd.sel_hi) begin
            addr_a = r_hi;
        end else if (i_cmd.sel_k) begin
            addr_a = r_k;
        end else begin
            addr_a = r_j;
        end
    end

    // One write port: a swap takes two writes in consecutive cycles.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = r_rd_b;
        priority if (i_cmd.load) begin
            mem_we    = has_room;
            mem_waddr = AW'(r_count);
            mem_wdata = i_value;
        end else if (i_cmd.step) begin
            mem_we    = j_at_hi || less;
            mem_waddr = r_i;
            mem_wdata = r_rd_a;
        end else if (i_cmd.swap_hi) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        stk_we    = 1'b0;
        stk_wdata = {QSL_FIELD_W'(r_i + AW'(1)), QSL_FIELD_W'(r_hi)};
        priority if (i_cmd.seed) begin
            stk_we    = (r_count >= CW'(2));
            stk_wdata = {QSL_FIELD_W'(0), QSL_FIELD_W'(r_count - CW'(1))};
        end else if (i_cmd.push_left) begin
            stk_we    = push_l_ok && stk_room;
            stk_wdata = {QSL_FIELD_W'(r_lo), QSL_FIELD_W'(r_i - AW'(1))};
        end else if (i_cmd.push_right) begin
            stk_we = push_r_ok && stk_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[i_cmd.seed ? AW'(0) : AW'(r_sp)] <= stk_wdata;
        end
        r_stk_rd <= r_stk[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sp     <= '0;
            r_ovf    <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (has_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.seed) begin
                r_sp <= (r_count >= CW'(2)) ? CW'(1) : CW'(0);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - CW'(1);
            end else if (stk_we) begin
                r_sp <= r_sp + CW'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                if (!k_last) begin
                    r_k <= r_k + AW'(1);
                end
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_sp    <= '0;
                r_ovf   <= 1'b0;
                r_k     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_range) begin
            r_lo <= AW'(pop_lo);
            r_hi <= AW'(pop_hi);
        end
        if (i_cmd.take_pivot) begin
            r_pivot <= r_rd_a;
            r_i     <= r_lo;
            r_j     <= r_lo;
        end
        if (i_cmd.step) begin
            if (less && !j_at_hi) begin
                r_i <= r_i + AW'(1);
            end
            if (!(less || j_at_hi)) begin
                r_j <= r_j + AW'(1);
            end
        end
        if (i_cmd.swap_hi && !j_at_hi) begin
            r_j <= r_j + AW'(1);
        end
        if (i_cmd.emit) begin
            r_odata <= r_rd_a;
            r_olast <= k_last;
            r_oovf  <= r_ovf;
        end
    end

    assign o_sts.sp_nz    = (r_sp != '0);
    assign o_sts.range_ok = (pop_lo < pop_hi) &&
                            ({1'b0, pop_hi} < (QSL_FIELD_W + 1)'(DEPTH));
    assign o_sts.less     = less;
    assign o_sts.j_at_hi  = j_at_hi;
    assign o_sts.k_last   = k_last;
    assign o_sts.out_free = !r_ovalid || i_m_tready;

    assign o_m_tvalid     = r_ovalid;
    assign o_sorted_value = r_odata;
    assign o_last_out     = r_olast;
    assign o_overflow     = r_oovf;

endmodule

// ----- tb/quicksort_lomuto_top_tb.sv -----
`timescale 1ns / 1ps

module quicksort_lomuto_top_tb;

    import qsl_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int STORE_DEPTH   = QSL_DEPTH;
    // Longest stretch with no beat on either side before the run is declared hung.
    // A full store sorts well within this limit, a presorted one being the slowest, and
    // the long receiver hold-off adds to the stretch.
    localparam int STALL_LIMIT   = 40000;
    // A stray output beat would show up well within this settling time.
    localparam int SETTLE_CYCLES = 100;

    typedef logic signed [QSL_DATA_W-1:0] t_word;

    typedef struct {
        t_word value;
        logic  last;
        logic  ovf;
    } t_sorted_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    t_word       i_s_tdata;     // [31:0] value
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    t_word       o_m_tdata;     // [31:0] sorted_value
    logic        o_m_tlast;
    logic [0:0]  o_m_tuser;     // [0] overflow

    quicksort_lomuto_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the set being loaded into the block, and the sorted beats still owed.
    t_word          held_vals [STORE_DEPTH];
    int             held_cnt    = 0;
    logic           set_dropped = 1'b0;
    t_sorted_beat   sorted_expect_q [$];

    int  mismatches   = 0;
    int  stall_cycles = 0;
    bit  rst_done     = 1'b0;
    bit  quiet        = 1'b0;   // no idling on either side in the closing part
    int  hold_off     = 0;      // long receiver stall requested by a test
    bit  holding      = 1'b0;

    // Mirrors the block for one accepted input beat. Elements past the store depth
    // are dropped and mark the whole set; the last beat closes the set, which is
    // then sorted ascending as signed words.
    task automatic take_beat(input t_word v, input logic l);
        int           i;
        int           j;
        t_word        key;
        t_sorted_beat b;
        if (held_cnt < STORE_DEPTH) begin
            held_vals[held_cnt] = v;
            held_cnt++;
        end else begin
            set_dropped = 1'b1;
        end
        if (l) begin
            for (i = 1; i < held_cnt; i++) begin
                key = held_vals[i];
                j = i - 1;
                while (j >= 0 && held_vals[j] > key) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            for (i = 0; i < held_cnt; i++) begin
                b.value = held_vals[i];
                b.last  = (i == held_cnt - 1);
                b.ovf   = set_dropped;
                sorted_expect_q.push_back(b);
            end
            held_cnt    = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Offers one beat and returns at the edge where it is taken. A random gap may
    // come first, unless the caller wants the input kept busy.
    task automatic send_beat(input t_word v, input logic l, input bit may_idle);
        int gap;
        if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tlast  <= l;
        do @(posedge i_clk); while (!o_s_tready);
        take_beat(v, l);
    endtask

    task automatic send_set(input t_word vals[$], input bit may_idle);
        int k;
        for (k = 0; k < vals.size(); k++)
            send_beat(vals[k], k == vals.size() - 1, may_idle);
    endtask

    // Drops valid and waits until every owed beat has come back.
    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sorted_expect_q.size() != 0);
    endtask

    function automatic t_word random_value(input int mode);
        t_word pick;
        case (mode)
            0: pick = t_word'($urandom);
            1: pick = t_word'($urandom_range(0, 8)) - 4;   // dense duplicates
            2: begin
                case ($urandom_range(0, 3))
                    0: pick = 32'sh8000_0000;
                    1: pick = 32'sh7fff_ffff;
                    2: pick = '0;
                    default: pick = -1;
                endcase
            end
            default: pick = random_value($urandom_range(0, 2));
        endcase
        return pick;
    endfunction

    task automatic test_single_element();
        send_set('{32'sh8000_0000}, 1'b1);
        send_set('{32'sh7fff_ffff}, 1'b1);
        send_set('{32'sh0}, 1'b1);
    endtask

    task automatic test_extreme_values();
        send_set('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
                   32'sh8000_0001, 32'sh7fff_fffe}, 1'b1);
    endtask

    // Ties with the pivot stay on the right side of each partition.
    task automatic test_equal_values();
        send_set('{32'sd7, 32'sd7, -32'sd3, 32'sd7, -32'sd3, 32'sd7}, 1'b1);
    endtask

    task automatic test_presorted_sets();
        send_set('{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2}, 1'b1);
        send_set('{32'sd3, 32'sd1, 32'sd0, -32'sd5}, 1'b1);
    endtask

    // The store fills exactly and the last beat itself is one element too many,
    // so it is dropped while still closing the set.
    task automatic test_store_overflow();
        t_word vals[$];
        int    k;
        for (k = STORE_DEPTH; k >= 0; k--)
            vals.push_back(t_word'(k));
        send_set(vals, 1'b1);
    endtask

    // The receiver stalls for a long stretch while sets keep coming, so the output
    // register fills and the block has to hold off its input.
    task automatic test_output_backpressure();
        t_word vals[$];
        int    s;
        int    k;
        i_s_tvalid <= 1'b0;
        hold_off = 400;
        wait (holding);
        for (s = 0; s < 3; s++) begin
            vals.delete();
            for (k = 0; k < 3; k++)
                vals.push_back(random_value(3));
            send_set(vals, 1'b0);
        end
    endtask

    // The sender goes quiet until the block has returned everything it owes.
    task automatic test_drain_pause();
        t_word vals[$];
        int    k;
        for (k = 0; k < 4; k++)
            vals.push_back(random_value(0));
        send_set(vals, 1'b1);
        wait_results_drained();
        send_set('{random_value(0), random_value(1), random_value(2)}, 1'b1);
    endtask

    // Whole sets of random content; most are small, now and then one is longer.
    task automatic test_random_sets(input int n_items);
        t_word vals[$];
        int    sent;
        int    size;
        int    mode;
        int    k;
        sent = 0;
        while (sent < n_items) begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                               : $urandom_range(1, 5);
            mode = $urandom_range(0, 3);
            vals.delete();
            for (k = 0; k < size; k++)
                vals.push_back(random_value(mode));
            send_set(vals, 1'b1);
            sent += size;
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        test_single_element();
        test_extreme_values();
        test_equal_values();
        test_presorted_sets();
        test_store_overflow();
        test_output_backpressure();
        test_drain_pause();
        test_random_sets(5);
        quiet = 1'b1;
        test_random_sets(5);

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sorted_expect_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: ready in random bursts with random stalls, a long stall on request,
    // and always ready in the closing part.
    initial begin
        int n;
        i_m_tready <= 1'b0;
        wait (rst_done);
        forever begin
            if (hold_off > 0) begin
                n = hold_off;
                hold_off = 0;
                i_m_tready <= 1'b0;
                holding = 1'b1;
                repeat (n) @(posedge i_clk);
                holding = 1'b0;
            end else if (quiet) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                if (!quiet && $urandom_range(0, 2) == 0) begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
            end
        end
    end

    // Every accepted output beat is matched against the oldest owed beat.
    always @(posedge i_clk) begin
        t_sorted_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sorted_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value %0d last %0b overflow %0b",
                             o_m_tdata, o_m_tlast, o_m_tuser[0]);
            end else begin
                want = sorted_expect_q.pop_front();
                if (o_m_tdata !== want.value || o_m_tlast !== want.last ||
                    o_m_tuser[0] !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("beat mismatch: expected value %0d last %0b overflow %0b,",
                               want.value, want.last, want.ovf);
                        $display(" got value %0d last %0b overflow %0b",
                                 o_m_tdata, o_m_tlast, o_m_tuser[0]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
